[sv/setn_pkg.sv]
// ----------------------------------------------------------------------------
// setn_pkg
// Shared types, codes and controller interface for the sparse edge table
// normalizer.
// ----------------------------------------------------------------------------
package setn_pkg;

	// operation codes
	localparam logic [2:0] FUNC_ADD       = 3'd0;
	localparam logic [2:0] FUNC_GET       = 3'd1;
	localparam logic [2:0] FUNC_ROW_NORM  = 3'd2;
	localparam logic [2:0] FUNC_COL_NORM  = 3'd3;
	localparam logic [2:0] FUNC_TRANSPOSE = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_ZERO_SUM  = 2'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic [1:0]         edge_type;
		logic [15:0]        from_node;
		logic [15:0]        to_node;
		logic signed [31:0] edge_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [1:0]         status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,       // search for matching entry (add/get)
		S_SCAN_WAIT,  // read latency for last entry
		S_FINISH,     // add/get decide
		S_SUM_OUTER,  // start sum for entry e
		S_SUM_INNER,  // accumulate over k
		S_SUM_STORE,  // write scratch
		S_DIV_RD,     // read weight and scratch for entry e
		S_DIV_RUN,    // iterate divider
		S_DIV_WR,     // write back quotient
		S_XPOSE,      // swap row/column
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item, clear counters
		logic scan_step; // issue read at scan index, advance
		logic sum_begin; // set key from entry e, reset k, clear acc
		logic sum_step;  // issue read at k, advance
		logic sum_store; // write scratch[e], advance e
		logic div_read;  // issue read for entry e
		logic div_start; // load divider
		logic div_step;  // one divider iteration
		logic div_write; // write quotient, advance e
		logic xp_step;   // swap one entry, advance
		logic do_add;    // perform update or append
		logic reset_e;   // rewind entry counter
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;  // scan index reached list end
		logic found;      // a matching entry was seen
		logic list_empty;
		logic k_last;
		logic e_last;
		logic div_done;
		logic xp_last;    // transpose sweep finished
		logic type_ok;
	} sts_t;

endpackage

[sv/setn_ctrl.sv]
// ----------------------------------------------------------------------------
// setn_ctrl
// Operation sequencer: scans, summing/dividing passes, transpose sweep.
// ----------------------------------------------------------------------------
module setn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [2:0]          func,
	input  setn_pkg::sts_t      sts,
	input  logic                out_free,
	output setn_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                finish
);

	setn_pkg::state_t state_q, state_d;
	logic [2:0] func_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= setn_pkg::S_IDLE;
			func_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) func_q <= func;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		finish  = 1'b0;
		busy    = (state_q != setn_pkg::S_IDLE);
		unique case (state_q)
			setn_pkg::S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = setn_pkg::S_SCAN;
				end
			end
			setn_pkg::S_SCAN: begin
				if (func_q == setn_pkg::FUNC_ADD || func_q == setn_pkg::FUNC_GET) begin
					if (!sts.type_ok || sts.scan_last) state_d = setn_pkg::S_SCAN_WAIT;
					else cmd.scan_step = 1'b1;
				end else if (func_q == setn_pkg::FUNC_ROW_NORM ||
						func_q == setn_pkg::FUNC_COL_NORM) begin
					if (!sts.type_ok || sts.list_empty) state_d = setn_pkg::S_DONE;
					else state_d = setn_pkg::S_SUM_OUTER;
				end else if (func_q == setn_pkg::FUNC_TRANSPOSE) begin
					state_d = setn_pkg::S_XPOSE;
				end else begin
					state_d = setn_pkg::S_DONE;
				end
			end
			setn_pkg::S_SCAN_WAIT: state_d = setn_pkg::S_FINISH;
			setn_pkg::S_FINISH: begin
				if (func_q == setn_pkg::FUNC_ADD) cmd.do_add = 1'b1;
				state_d = setn_pkg::S_DONE;
			end
			setn_pkg::S_SUM_OUTER: begin
				cmd.sum_begin = 1'b1;
				state_d       = setn_pkg::S_SUM_INNER;
			end
			setn_pkg::S_SUM_INNER: begin
				if (sts.k_last) state_d = setn_pkg::S_SUM_STORE;
				else cmd.sum_step = 1'b1;
			end
			setn_pkg::S_SUM_STORE: begin
				cmd.sum_store = 1'b1;
				if (sts.e_last) begin
					cmd.reset_e = 1'b1;
					state_d     = setn_pkg::S_DIV_RD;
				end else begin
					state_d = setn_pkg::S_SUM_OUTER;
				end
			end
			setn_pkg::S_DIV_RD: begin
				cmd.div_read = 1'b1;
				state_d      = setn_pkg::S_DIV_RUN;
			end
			setn_pkg::S_DIV_RUN: begin
				if (sts.div_done) state_d = setn_pkg::S_DIV_WR;
				else cmd.div_step = 1'b1;
			end
			setn_pkg::S_DIV_WR: begin
				cmd.div_write = 1'b1;
				state_d = sts.e_last ? setn_pkg::S_DONE : setn_pkg::S_DIV_RD;
			end
			setn_pkg::S_XPOSE: begin
				if (sts.xp_last) state_d = setn_pkg::S_DONE;
				else cmd.xp_step = 1'b1;
			end
			setn_pkg::S_DONE: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = setn_pkg::S_IDLE;
				end
			end
			default: state_d = setn_pkg::S_IDLE;
		endcase
	end

endmodule

[sv/setn_div.sv]
// ----------------------------------------------------------------------------
// setn_div
// Radix-2 restoring divider, signed, truncating, saturating to 32 bits.
// ----------------------------------------------------------------------------
module setn_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                step,
	input  logic signed [31:0]  weight,
	input  logic signed [47:0]  divisor,
	output logic                done,
	output logic signed [31:0]  quot
);

	localparam int NW = 48; // |w*65536| <= 2^47, fits 48 bits
	logic [NW-1:0] rem_q, num_q, den_q;
	logic [NW-1:0] q_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	logic [NW:0]   trial;
	logic [NW-1:0] rem_sh;
	logic signed [NW-1:0] num_s;

	assign num_s  = {{16{weight[31]}}, weight} <<< 16;
	assign rem_sh = {rem_q[NW-2:0], num_q[NW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, den_q};
	assign done   = (cnt_q == 6'(NW));

	// iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'(NW);
		end else if (start) begin
			cnt_q <= '0;
		end else if (step && !done) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= '0;
			num_q <= num_s[NW-1] ? NW'(-num_s) : num_s;
			den_q <= divisor[47] ? NW'(-divisor) : divisor;
			neg_q <= num_s[NW-1] ^ divisor[47];
		end else if (step && !done) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	// sign and saturate
	always_comb begin
		if (!neg_q) quot = (q_q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q_q);
		else quot = (q_q > 48'h8000_0000) ? 32'sh8000_0000 : 32'(-q_q);
	end

endmodule

[sv/setn_dp.sv]
// ----------------------------------------------------------------------------
// setn_dp
// Datapath: entry memories, scratch sums, scan compare, accumulator.
// ----------------------------------------------------------------------------
module setn_dp #(
	parameter int MAX_EDGES = 1024,
	parameter int NUM_TYPES = 4,
	parameter int NODE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  setn_pkg::in_item_t  in_item,
	input  setn_pkg::cmd_t      cmd,
	output setn_pkg::sts_t      sts,
	output setn_pkg::out_item_t result
);

	localparam int EW = $clog2(MAX_EDGES);
	localparam int LW = $clog2(MAX_EDGES + 1);
	localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int AW = TW + EW;
	localparam int DEPTH = NUM_TYPES << EW;
	localparam int NB = (NODE_BITS < 16) ? NODE_BITS : 16;

	logic [NB-1:0]      row_mem [DEPTH];
	logic [NB-1:0]      col_mem [DEPTH];
	logic signed [31:0] wt_mem  [DEPTH];
	logic signed [47:0] sum_mem [MAX_EDGES];
	logic [LW-1:0]      len_q   [NUM_TYPES];

	setn_pkg::in_item_t it_q;
	setn_pkg::in_item_t ld_item;
	logic [TW-1:0] typ_q;
	logic [LW-1:0] idx_q, e_q, k_q, n_q;
	logic [TW:0]   xt_q;
	logic          found_q, hit_pend_q, zero_q;
	logic [EW-1:0] fidx_q, rd_idx_q;
	logic [TW-1:0] xp_t_q;
	logic          rd_v_q;
	logic [NB-1:0] key_q;
	logic signed [47:0] acc_q;
	logic [1:0]    st_q;
	logic          sum_key_pend_q, sum_act_q;
	logic signed [31:0] wt_fetch_q;

	logic [NB-1:0]      rd_row, rd_col;
	logic signed [31:0] rd_wt;
	logic signed [47:0] rd_sum;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [EW-1:0]      rd_e;
	logic               rd_en, wr_row, wr_col, wr_wt;
	logic [NB-1:0]      wd_row, wd_col;
	logic signed [31:0] wd_wt;
	logic               div_done;
	logic signed [31:0] quot;
	logic               type_ok;
	logic [NB-1:0]      r_in, c_in;
	logic [TW-1:0]      xt_t;
	logic               match_hit;
	logic [NB-1:0]      grp_key;

	assign type_ok = 32'(it_q.edge_type) < NUM_TYPES;
	assign r_in    = NB'(in_item.from_node);
	assign c_in    = NB'(in_item.to_node);
	assign xt_t    = xt_q[TW-1:0];

	// scan hit on the entry read last cycle
	assign match_hit = hit_pend_q && !found_q && rd_row == key_q &&
		rd_col == it_q.to_node[NB-1:0];
	assign grp_key = (it_q.func == setn_pkg::FUNC_ROW_NORM) ? rd_row : rd_col;

	// node indices masked at capture
	always_comb begin
		ld_item           = in_item;
		ld_item.from_node = 16'(r_in);
		ld_item.to_node   = 16'(c_in);
	end

	// read address select
	always_comb begin
		rd_en = 1'b1;
		rd_e  = EW'(idx_q);
		if (cmd.sum_begin || cmd.div_read) rd_e = EW'(e_q);
		else if (cmd.sum_step) rd_e = EW'(k_q);
		rd_addr = {typ_q, rd_e};
		if (cmd.xp_step) rd_addr = {xt_t, EW'(idx_q)};
	end

	// write port select
	always_comb begin
		wr_row = 1'b0; wr_col = 1'b0; wr_wt = 1'b0;
		wr_addr = {typ_q, EW'(len_q[typ_q])};
		wd_row = it_q.from_node[NB-1:0];
		wd_col = it_q.to_node[NB-1:0];
		wd_wt  = it_q.edge_value;
		if (cmd.do_add && type_ok) begin
			if (found_q) begin
				wr_wt = 1'b1; wr_addr = {typ_q, fidx_q};
			end else if (32'(len_q[typ_q]) < MAX_EDGES) begin
				wr_row = 1'b1; wr_col = 1'b1; wr_wt = 1'b1;
			end
		end else if (cmd.div_write && !zero_q) begin
			wr_wt = 1'b1; wr_addr = {typ_q, EW'(e_q)}; wd_wt = quot;
		end else if (rd_v_q) begin
			// transpose write-back in the cycle after the read
			wr_row = 1'b1; wr_col = 1'b1;
			wr_addr = {xp_t_q, rd_idx_q};
			wd_row = rd_col; wd_col = rd_row;
		end
	end

	// entry memories
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= row_mem[rd_addr];
			rd_col <= col_mem[rd_addr];
			rd_wt  <= wt_mem[rd_addr];
		end
		if (wr_row) row_mem[wr_addr] <= wd_row;
		if (wr_col) col_mem[wr_addr] <= wd_col;
		if (wr_wt)  wt_mem[wr_addr]  <= wd_wt;
	end

	// scratch sums
	always_ff @(posedge clk) begin
		rd_sum <= sum_mem[EW'(e_q)];
		if (cmd.sum_store) sum_mem[EW'(e_q)] <= acc_q;
	end

	// list lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TYPES; i++) len_q[i] <= '0;
		end else if (cmd.do_add && type_ok && !found_q &&
				32'(len_q[typ_q]) < MAX_EDGES) begin
			len_q[typ_q] <= len_q[typ_q] + 1'b1;
		end
	end

	// control counters and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; e_q <= '0; k_q <= '0; xt_q <= '0;
			found_q <= 1'b0; hit_pend_q <= 1'b0; rd_v_q <= 1'b0; zero_q <= 1'b0;
		end else begin
			hit_pend_q <= cmd.scan_step || cmd.sum_step || cmd.xp_step;
			rd_v_q     <= cmd.xp_step;
			if (cmd.load) begin
				idx_q <= '0; e_q <= '0; k_q <= '0; xt_q <= '0;
				found_q <= 1'b0; zero_q <= 1'b0;
			end
			if (cmd.scan_step) idx_q <= idx_q + 1'b1;
			if (match_hit) found_q <= 1'b1;
			if (cmd.sum_begin) k_q <= '0;
			if (cmd.sum_step) k_q <= k_q + 1'b1;
			if (cmd.reset_e) e_q <= '0;
			else if (cmd.sum_store || cmd.div_write) e_q <= e_q + 1'b1;
			if (cmd.div_start) zero_q <= (rd_sum == '0);
			if (cmd.xp_step) begin
				if (32'(idx_q) + 1 >= 32'(len_q[xt_t])) begin
					idx_q <= '0; xt_q <= xt_q + 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// item capture, key, accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q  <= ld_item;
			typ_q <= TW'(in_item.edge_type);
			key_q <= r_in;
		end
		if (cmd.scan_step) rd_idx_q <= EW'(idx_q);
		if (cmd.xp_step) begin
			rd_idx_q <= EW'(idx_q);
			xp_t_q   <= xt_t;
		end
		if (match_hit) fidx_q <= rd_idx_q;
		if (cmd.sum_step) rd_idx_q <= EW'(k_q);
		if (cmd.sum_begin) acc_q <= '0;
		if (sum_act_q && grp_key == key_q)
			acc_q <= acc_q + 48'(rd_wt);
		if (sum_key_pend_q) key_q <= grp_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_key_pend_q <= 1'b0; sum_act_q <= 1'b0;
		end else begin
			sum_key_pend_q <= cmd.sum_begin;
			sum_act_q      <= cmd.sum_step;
		end
	end

	// status register: zero sum flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= setn_pkg::ST_OK;
		else if (cmd.load) st_q <= setn_pkg::ST_OK;
		else if (cmd.div_write && zero_q) st_q <= setn_pkg::ST_ZERO_SUM;
	end

	setn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.step    (cmd.div_step),
		.weight  (rd_wt),
		.divisor (rd_sum),
		.done    (div_done),
		.quot    (quot)
	);

	// length snapshot at load (full detection) and found weight fetch
	always_ff @(posedge clk) begin
		if (cmd.load) n_q <= len_q[TW'(in_item.edge_type)];
		if (match_hit) wt_fetch_q <= rd_wt;
	end

	// result formation
	always_comb begin
		result.value_out = '0;
		result.status    = setn_pkg::ST_OK;
		unique case (it_q.func)
			setn_pkg::FUNC_ADD: begin
				if (!type_ok) result.status = setn_pkg::ST_FULL;
				else if (!found_q && 32'(len_q[typ_q]) >= MAX_EDGES &&
						n_q == len_q[typ_q])
					result.status = setn_pkg::ST_FULL;
			end
			setn_pkg::FUNC_GET: begin
				if (type_ok && found_q) result.value_out = wt_fetch_q;
				else result.status = setn_pkg::ST_NOT_FOUND;
			end
			setn_pkg::FUNC_ROW_NORM, setn_pkg::FUNC_COL_NORM: result.status = st_q;
			default: ;
		endcase
	end

	assign sts.scan_last  = (idx_q >= len_q[typ_q]);
	assign sts.found      = found_q;
	assign sts.list_empty = (len_q[typ_q] == '0);
	assign sts.k_last     = (k_q >= len_q[typ_q]);
	assign sts.e_last     = (e_q + 1'b1 >= len_q[typ_q]);
	// divider count is stale in the cycle it is loaded
	assign sts.div_done   = div_done && !cmd.div_start;
	assign sts.xp_last    = (32'(xt_q) >= NUM_TYPES);
	assign sts.type_ok    = type_ok;

endmodule

[sv/sparse_edge_table_normalizer_unit.sv]
// ----------------------------------------------------------------------------
// sparse_edge_table_normalizer_unit
// Coordinate-list sparse matrix store with add, get, normalize, transpose.
// ----------------------------------------------------------------------------
// One item at a time. Add and get scan the type's list, one entry per cycle.
// Row/column normalize first sums each entry's group through one memory read
// port, then divides each entry with a 48-step serial divider (per entry:
// read, load, 48 steps, done, write). Transpose sweeps all lists, one entry
// per cycle, an empty list still taking one sweep step. The result sits in
// an output register until taken; the next input beat may be accepted
// meanwhile, but its result waits for it.
module sparse_edge_table_normalizer_unit #(
	parameter int MAX_EDGES = 1024,
	parameter int NUM_TYPES = 4,
	parameter int NODE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  setn_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output setn_pkg::out_item_t out_data
);

	setn_pkg::cmd_t      cmd, cmd_dp;
	setn_pkg::sts_t      sts;
	setn_pkg::out_item_t res;
	logic busy, finish, in_fire, div_start_q;

	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;

	setn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.func     (in_data.func),
		.sts      (sts),
		.out_free (!out_valid),
		.cmd      (cmd),
		.busy     (busy),
		.finish   (finish)
	);

	// divider start is registered from the operand read, in the cycle after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_start_q <= 1'b0;
		else div_start_q <= cmd.div_read;
	end

	always_comb begin
		cmd_dp = cmd;
		cmd_dp.div_start = div_start_q;
		cmd_dp.div_step  = cmd.div_step && !div_start_q;
	end

	setn_dp #(
		.MAX_EDGES (MAX_EDGES),
		.NUM_TYPES (NUM_TYPES),
		.NODE_BITS (NODE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_data),
		.cmd     (cmd_dp),
		.sts     (sts),
		.result  (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (finish) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) out_data <= res;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while waiting");
	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid) else $error("result not registered");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> !busy) else $error("controller not idle after result");

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Sparse edge table normalizer testbench
// Drives add, get, row/column normalize and transpose beats into the unit.
// A software copy of the four coordinate lists predicts every result, and
// each returned beat is compared in order. Sender bursts and receiver stalls
// are randomized.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_CAP   = 1024;
	localparam int TYPE_COUNT = 4;
	localparam logic [2:0] FUNC_TOP = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	setn_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	setn_pkg::out_item_t out_data;

	sparse_edge_table_normalizer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// shadow copy of the edge lists
	logic [15:0]        shadow_row [TYPE_COUNT][LIST_CAP];
	logic [15:0]        shadow_col [TYPE_COUNT][LIST_CAP];
	logic signed [31:0] shadow_wt  [TYPE_COUNT][LIST_CAP];
	int                 shadow_len [TYPE_COUNT];
	longint             group_sums [LIST_CAP];

	setn_pkg::out_item_t pending_results[$];
	int                  fail_count;
	int                  burst_left;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic int lookup_entry(int t, logic [15:0] r, logic [15:0] c);
		for (int e = 0; e < shadow_len[t]; e++)
			if (shadow_row[t][e] == r && shadow_col[t][e] == c)
				return e;
		return -1;
	endfunction

	// sums per group first, then divide with saturation
	function automatic logic [1:0] normalize_list(int t, bit by_row);
		logic   zero_seen;
		longint q;
		zero_seen = 1'b0;
		for (int e = 0; e < shadow_len[t]; e++) begin
			group_sums[e] = 0;
			for (int k = 0; k < shadow_len[t]; k++)
				if ((by_row ? shadow_row[t][k] : shadow_col[t][k]) ==
				    (by_row ? shadow_row[t][e] : shadow_col[t][e]))
					group_sums[e] += longint'(shadow_wt[t][k]);
		end
		for (int e = 0; e < shadow_len[t]; e++) begin
			if (group_sums[e] == 0) begin
				zero_seen = 1'b1;
				continue;
			end
			q = (longint'(shadow_wt[t][e]) * 65536) / group_sums[e];
			if (q > 64'sd2147483647) q = 64'sd2147483647;
			if (q < -64'sd2147483648) q = -64'sd2147483648;
			shadow_wt[t][e] = q[31:0];
		end
		return zero_seen ? setn_pkg::ST_ZERO_SUM : setn_pkg::ST_OK;
	endfunction

	function automatic setn_pkg::out_item_t apply_beat(setn_pkg::in_item_t it);
		setn_pkg::out_item_t res;
		int                  t;
		int                  idx;
		logic [15:0]         tmp;
		res = '0;
		res.status = setn_pkg::ST_OK;
		t = it.edge_type;
		case (it.func)
			setn_pkg::FUNC_ADD: begin
				idx = lookup_entry(t, it.from_node, it.to_node);
				if (idx >= 0) begin
					shadow_wt[t][idx] = it.edge_value;
				end else if (shadow_len[t] < LIST_CAP) begin
					shadow_row[t][shadow_len[t]] = it.from_node;
					shadow_col[t][shadow_len[t]] = it.to_node;
					shadow_wt[t][shadow_len[t]] = it.edge_value;
					shadow_len[t]++;
				end else begin
					res.status = setn_pkg::ST_FULL;
				end
			end
			setn_pkg::FUNC_GET: begin
				idx = lookup_entry(t, it.from_node, it.to_node);
				if (idx >= 0) res.value_out = shadow_wt[t][idx];
				else res.status = setn_pkg::ST_NOT_FOUND;
			end
			setn_pkg::FUNC_ROW_NORM: res.status = normalize_list(t, 1'b1);
			setn_pkg::FUNC_COL_NORM: res.status = normalize_list(t, 1'b0);
			setn_pkg::FUNC_TRANSPOSE: begin
				for (int a = 0; a < TYPE_COUNT; a++)
					for (int e = 0; e < shadow_len[a]; e++) begin
						tmp = shadow_row[a][e];
						shadow_row[a][e] = shadow_col[a][e];
						shadow_col[a][e] = tmp;
					end
			end
			default: ;
		endcase
		return res;
	endfunction

	// send one beat; inputs change on the falling edge
	task automatic send_beat(logic [2:0] f, logic [1:0] t, logic [15:0] r,
	                         logic [15:0] c, logic [31:0] w, bit bursty = 1'b1);
		setn_pkg::in_item_t it;
		it = '{func: f, edge_type: t, from_node: r, to_node: c, edge_value: w};
		if (bursty && burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 15);
		end
		if (burst_left > 0) burst_left--;
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
		pending_results = {pending_results, apply_beat(it)};
		@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		setn_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value=%h status=%0d", $realtime,
				         out_data.value_out, out_data.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.value_out !== want.value_out) begin
					$display("%0t: value_out expected %h got %h", $realtime,
					         want.value_out, out_data.value_out);
					fail_count++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $realtime,
					         want.status, out_data.status);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern: modes of always ready, periodic and random
	always @(negedge clk) begin
		int phase;
		int mode;
		phase = phase + 1;
		if (phase % 300 == 0) mode = $urandom_range(0, 2);
		case (mode)
			0: out_ready <= 1'b1;
			1: out_ready <= (phase % 5) < 2;
			default: out_ready <= $urandom_range(0, 3) != 0;
		endcase
	end

	function automatic logic [15:0] pick_node();
		return ($urandom_range(0, 99) < 88) ? 16'($urandom_range(0, 3))
		                                    : 16'($urandom);
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(0, 3))
			0: return 32'($urandom);
			1: return 32'(0);
			default: return 32'(($urandom_range(0, 8) - 4) * 65536 + $urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_add_get();
		send_beat(setn_pkg::FUNC_ADD, 2'd0, 16'h0000, 16'hFFFF, 32'h7FFFFFFF);
		send_beat(setn_pkg::FUNC_ADD, 2'd0, 16'hFFFF, 16'h0000, 32'h80000000);
		send_beat(setn_pkg::FUNC_ADD, 2'd0, 16'h0000, 16'h0001, 32'h00010000);
		send_beat(setn_pkg::FUNC_GET, 2'd0, 16'h0000, 16'hFFFF, 32'h0);
		send_beat(setn_pkg::FUNC_GET, 2'd0, 16'hFFFF, 16'h0000, 32'h0);
		send_beat(setn_pkg::FUNC_GET, 2'd0, 16'hFFFF, 16'hFFFF, 32'h0);
		send_beat(setn_pkg::FUNC_ADD, 2'd0, 16'h0000, 16'h0001, 32'hFFFF0000);
		send_beat(setn_pkg::FUNC_GET, 2'd0, 16'h0000, 16'h0001, 32'h0);
		send_beat(setn_pkg::FUNC_GET, 2'd2, 16'h0000, 16'h0001, 32'h0);
	endtask

	task automatic test_normalize();
		send_beat(setn_pkg::FUNC_ROW_NORM, 2'd2, 16'h0, 16'h0, 32'h0);   // empty list
		send_beat(setn_pkg::FUNC_ROW_NORM, 2'd0, 16'h0, 16'h0, 32'h0);
		send_beat(setn_pkg::FUNC_COL_NORM, 2'd0, 16'h0, 16'h0, 32'h0);
		// cancelling row gives a zero sum; near-cancelling row saturates
		send_beat(setn_pkg::FUNC_ADD, 2'd1, 16'd1, 16'd1, 32'h00050000);
		send_beat(setn_pkg::FUNC_ADD, 2'd1, 16'd1, 16'd2, 32'hFFFB0000);
		send_beat(setn_pkg::FUNC_ADD, 2'd1, 16'd9, 16'd1, 32'h7FFFFFFF);
		send_beat(setn_pkg::FUNC_ADD, 2'd1, 16'd9, 16'd2, 32'h80000002);
		send_beat(setn_pkg::FUNC_ROW_NORM, 2'd1, 16'h0, 16'h0, 32'h0);
		send_beat(setn_pkg::FUNC_COL_NORM, 2'd1, 16'h0, 16'h0, 32'h0);
	endtask

	task automatic test_transpose_and_spare();
		send_beat(setn_pkg::FUNC_TRANSPOSE, 2'd3, 16'h0, 16'h0, 32'h0);
		send_beat(setn_pkg::FUNC_GET, 2'd0, 16'hFFFF, 16'h0000, 32'h0);
		for (int f = setn_pkg::FUNC_TRANSPOSE + 1; f <= FUNC_TOP; f++)
			send_beat(3'(f), 2'($urandom), 16'($urandom), 16'($urandom), $urandom);
	endtask

	task automatic test_random(int count);
		int          sel;
		logic [2:0]  f;
		logic [1:0]  t;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 42) f = setn_pkg::FUNC_ADD;
			else if (sel < 66) f = setn_pkg::FUNC_GET;
			else if (sel < 78) f = setn_pkg::FUNC_ROW_NORM;
			else if (sel < 90) f = setn_pkg::FUNC_COL_NORM;
			else if (sel < 95) f = setn_pkg::FUNC_TRANSPOSE;
			else f = 3'($urandom_range(setn_pkg::FUNC_TRANSPOSE + 1, FUNC_TOP));
			t = 2'($urandom_range(0, TYPE_COUNT - 1));
			send_beat(f, t, pick_node(), pick_node(), pick_weight());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		fail_count = 0;
		burst_left = 0;
		for (int t = 0; t < TYPE_COUNT; t++) shadow_len[t] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_add_get();
		test_normalize();
		test_transpose_and_spare();
		test_random(557);

		in_valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("status: fail");
		$finish;
	end
endmodule
